@@ design/assert_macros.svh @@
// Assertion macros for the verification files of the PID controller.
// No dependencies; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is low.
`define PPID_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define PPID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ppid_pkg.sv @@
// Widths and register indexes for the positional PID controller.
// No dependencies; imported by the controller and the testbench.
package ppid_pkg;

    localparam int IN_W    = 16;   // target and measured samples
    localparam int ERR_W   = 17;   // target - measured, exact
    localparam int DIFF_W  = 18;   // error - previous error
    localparam int INT_W   = 26;   // stored integral
    localparam int GAIN_W  = 16;
    localparam int WIN_W   = 16;
    localparam int IMAX_W  = 24;
    localparam int OMAX_W  = 15;
    localparam int DRIVE_W = 16;

    localparam int P_PROD_W = GAIN_W + 1 + ERR_W;
    localparam int D_PROD_W = GAIN_W + 1 + DIFF_W;
    localparam int I_PROD_W = GAIN_W + 1 + INT_W;
    localparam int SUM_W    = I_PROD_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_WINDOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX      = 3'd5;

    localparam logic [OMAX_W-1:0] OUT_MAX_RESET = 15'h7FFF;

endpackage

@@ design/position_pid_controller_unit.sv @@
// Positional PID controller with integral separation, three-stage pipeline.
// Depends on ppid_pkg.
//
// Usage:
//   s_tdata carries one sample: target in bits 15:0, measured in bits 31:16.
//   m_tdata carries the clamped drive, m_tuser flags that clamping occurred.
//   Gains, separation window and limits are written on the cfg_* port while
//   the block is idle; a write takes effect at the clock edge where cfg_we
//   is high. Indexes beyond the register list are ignored.
//   Stage one forms the error, the derivative difference and updates the
//   integral and previous error at the edge where the sample is accepted.
//   Stage two holds the three gain products, stage three the shifted and
//   clamped sum in the output register.
//   An accepted sample moves through stages two and three to m_tvalid. One
//   sample can be accepted every cycle; the short error and integral update
//   that feeds the next sample is the only loop, so it never limits the rate.
//   When m_tready is low, the stages fill one by one; s_tready drops only
//   once all three hold a sample, and results are never dropped.
//   A low aresetn clears the pipeline, the integral, the previous error and
//   the registers (out_max resets to 32767, everything else to zero).
module position_pid_controller_unit
    import ppid_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // target [15:0], measured [31:16]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // drive [15:0]
    output logic                  m_tuser,   // clamped [0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers.
    logic [GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [WIN_W-1:0]  sep_win_reg;
    logic [IMAX_W-1:0] int_max_reg;
    logic [OMAX_W-1:0] out_max_reg;

    // Loop state.
    logic signed [INT_W-1:0] integ_reg;
    logic signed [ERR_W-1:0] prev_err_reg;

    // Pipeline.
    logic                      v1_reg, v2_reg, v3_reg;
    logic signed [ERR_W-1:0]    err_s1_reg;
    logic signed [DIFF_W-1:0]   diff_s1_reg;
    logic signed [INT_W-1:0]    int_s1_reg;
    logic signed [P_PROD_W-1:0] p_prod_reg;
    logic signed [D_PROD_W-1:0] d_prod_reg;
    logic signed [I_PROD_W-1:0] i_prod_reg;
    logic [DRIVE_W-1:0]         drive_reg;
    logic                       clamped_reg;

    logic rdy1, rdy2, rdy3, accept;

    logic signed [IN_W-1:0]   target, measured;
    logic signed [ERR_W-1:0]  err_c;
    logic [ERR_W-1:0]         mag_c;
    logic                     integ_en_c;
    logic signed [INT_W-1:0]  int_upd_c, int_hi_c, imax_s, int_next;
    logic signed [DIFF_W-1:0] diff_c;

    logic signed [P_PROD_W-1:0] p_prod_next;
    logic signed [D_PROD_W-1:0] d_prod_next;
    logic signed [I_PROD_W-1:0] i_prod_next;

    logic signed [SUM_W-1:0] sum_c, shifted_c, omax_s;
    logic [DRIVE_W-1:0]      drive_next;
    logic                    clamped_next;

    // Each stage can load when it is empty or its contents move on.
    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign accept   = s_tvalid && rdy1;

    // Stage one: error, separation test and integral update.
    always_comb begin
        target     = $signed(s_tdata[15:0]);
        measured   = $signed(s_tdata[31:16]);
        err_c      = ERR_W'(target) - ERR_W'(measured);
        mag_c      = err_c[ERR_W-1] ? ERR_W'(-err_c) : err_c;
        integ_en_c = mag_c <= {1'b0, sep_win_reg};
        // Outside the window the integral is cleared and drops out of the drive.
        int_upd_c  = integ_en_c ? (integ_reg + INT_W'(err_c)) : '0;
        imax_s     = $signed({2'b00, int_max_reg});
        int_hi_c   = (int_upd_c >= imax_s) ? imax_s : int_upd_c;
        int_next   = (int_hi_c <= -imax_s) ? -imax_s : int_hi_c;
        diff_c     = DIFF_W'(err_c) - DIFF_W'(prev_err_reg);
    end

    // Stage two: gain products. Gains are unsigned, so a zero sign bit is added.
    always_comb begin
        p_prod_next = $signed({1'b0, gain_p_reg}) * err_s1_reg;
        d_prod_next = $signed({1'b0, gain_d_reg}) * diff_s1_reg;
        i_prod_next = $signed({1'b0, gain_i_reg}) * int_s1_reg;
    end

    // Stage three: sum, floor shift and output clamp.
    always_comb begin
        sum_c        = SUM_W'(p_prod_reg) + SUM_W'(d_prod_reg) + SUM_W'(i_prod_reg);
        shifted_c    = sum_c >>> GAIN_FRAC_BITS;
        omax_s       = $signed({{(SUM_W-OMAX_W){1'b0}}, out_max_reg});
        drive_next   = DRIVE_W'(shifted_c);
        clamped_next = 1'b0;
        if (shifted_c > omax_s) begin
            drive_next   = DRIVE_W'(omax_s);
            clamped_next = 1'b1;
        end else if (shifted_c < -omax_s) begin
            drive_next   = DRIVE_W'(-omax_s);
            clamped_next = 1'b1;
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            sep_win_reg <= '0;
            int_max_reg <= '0;
            out_max_reg <= OUT_MAX_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GAIN_P:       gain_p_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:       gain_i_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:       gain_d_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_SEP_WINDOW:   sep_win_reg <= cfg_wdata[WIN_W-1:0];
                REG_INTEGRAL_MAX: int_max_reg <= cfg_wdata[IMAX_W-1:0];
                REG_OUT_MAX:      out_max_reg <= cfg_wdata[OMAX_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state: valids and loop state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (accept) begin
                integ_reg    <= int_next;
                prev_err_reg <= err_c;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            err_s1_reg  <= err_c;
            diff_s1_reg <= diff_c;
            int_s1_reg  <= int_upd_c;
        end
        if (rdy2 && v1_reg) begin
            p_prod_reg <= p_prod_next;
            d_prod_reg <= d_prod_next;
            i_prod_reg <= i_prod_next;
        end
        if (rdy3 && v2_reg) begin
            drive_reg   <= drive_next;
            clamped_reg <= clamped_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = clamped_reg;

endmodule

@@ design/ppid_checker.sv @@
// Port-level checker for the positional PID controller, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ppid_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result holds its payload.
    `PPID_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Reset empties the pipeline.
    `PPID_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // The clamp limit is at most 32767, so the most negative code never appears.
    `PPID_ASSERT(a_drive_range, aclk, aresetn, m_tvalid |-> m_tdata != 16'h8000, "drive outside clamp range")

    // With no result waiting, every stage can move and a request is taken.
    `PPID_ASSERT(a_ready_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled with empty output")

    // An accepted request moves through the stages to m_tvalid while the receiver takes results.
    `PPID_ASSERT(a_latency, aclk, aresetn, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid, "result missing after pipeline latency")

endmodule

bind position_pid_controller_unit ppid_checker u_ppid_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the positional PID controller with integral separation.
// Uses ppid_pkg for widths and register indexes and drives position_pid_controller_unit.
`timescale 1ns / 100ps

module tb
    import ppid_pkg::*;
();

    localparam int GAIN_FRAC    = 8;
    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 100;
    localparam int N_DIRECTED   = 25;
    localparam int N_SETTINGS   = 7;

    // Indexes past the register list; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
    } pid_result_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [WIN_W-1:0]  window;
        logic [IMAX_W-1:0] imax;
        logic [OMAX_W-1:0] omax;
    } pid_settings_t;

    typedef struct packed {
        logic [2:0]                setting;
        logic signed [IN_W-1:0]    target;
        logic signed [IN_W-1:0]    measured;
        logic                      typed;
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;    // target [15:0], measured [31:16]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;         // drive [15:0]
    logic                  m_tuser;         // clamped [0]
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Register copy and controller state used for prediction.
    logic [GAIN_W-1:0] kp, ki, kd;
    logic [WIN_W-1:0]  sep_window;
    logic [IMAX_W-1:0] integ_limit;
    logic [OMAX_W-1:0] drive_limit;
    longint            integ_acc;
    longint            prev_err_model;

    pid_result_t drive_queue[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          send_steady = 1'b0;
    bit          recv_steady = 1'b0;

    position_pid_controller_unit #(
        .GAIN_FRAC_BITS(GAIN_FRAC)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Setting 0 is the reset state and is never written.
    pid_settings_t directed_settings [N_SETTINGS] = '{
        '{0,     0,     0,     0,     0,        32767},
        '{256,   0,     0,     0,     0,        0},
        '{256,   0,     0,     0,     0,        100},
        '{256,   128,   512,   1000,  0,        32767},
        '{65535, 65535, 65535, 65535, 16777215, 32767},
        '{256,   64,    128,   1000,  5000,     32767},
        '{256,   64,    128,   1000,  10,       32767}
    };

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{0,  32767, -32768, 1, 0,    0},
        '{0, -32768,  32767, 1, 0,    0},
        '{0,      0,      0, 1, 0,    0},
        '{1,    100,      0, 1, 0,    1},
        '{1,      0,      0, 1, 0,    0},
        '{1, -32768,  32767, 1, 0,    1},
        '{2,    100,      0, 1, 100,  0},
        '{2,      0,    101, 1, -100, 1},
        '{2, -32768,  32767, 1, -100, 1},
        '{2,  32767, -32768, 1, 100,  1},
        '{3,    500,      0, 0, 0,    0},
        '{3,    400,    300, 0, 0,    0},
        '{3,  -2000,      0, 0, 0,    0},
        '{3,   1000,      0, 0, 0,    0},
        '{3,  -1001,      0, 0, 0,    0},
        '{4,  32767, -32768, 0, 0,    0},
        '{4, -32768,  32767, 0, 0,    0},
        '{4,      1,      0, 0, 0,    0},
        '{5,    900,      0, 0, 0,    0},
        '{5,    900,      0, 0, 0,    0},
        '{5,    900,      0, 0, 0,    0},
        '{5,    800,      0, 0, 0,    0},
        '{5,    900,      0, 0, 0,    0},
        '{6,      1,      0, 0, 0,    0},
        '{6,     -1,      0, 0, 0,    0}
    };

    task automatic flag_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Runs of zero gaps alternate with random gaps so that both kinds of traffic occur.
    function automatic int draw_gap(inout bit steady);
        if ($urandom_range(0, 29) == 0)
            steady = !steady;
        return steady ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic signed [IN_W-1:0] sat16(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[IN_W-1:0];
    endfunction

    // Computes the drive for one sample and advances the integral and previous error.
    function automatic pid_result_t predict_drive(input logic signed [IN_W-1:0] tgt,
                                                  input logic signed [IN_W-1:0] meas);
        longint      err, mag, acc, lim_i, lim_o, shifted;
        pid_result_t r;
        err = longint'(tgt) - longint'(meas);
        mag = (err < 0) ? -err : err;
        acc = longint'(kp) * err + longint'(kd) * (err - prev_err_model);
        if (mag <= longint'(sep_window)) begin
            integ_acc += err;
            acc += longint'(ki) * integ_acc;
        end else begin
            integ_acc = 0;
        end
        lim_i = longint'(integ_limit);
        if (integ_acc >= lim_i)
            integ_acc = lim_i;
        if (integ_acc <= -lim_i)
            integ_acc = -lim_i;
        shifted = acc >>> GAIN_FRAC;
        lim_o = longint'(drive_limit);
        r.clamped = 1'b0;
        if (shifted > lim_o) begin
            shifted = lim_o;
            r.clamped = 1'b1;
        end else if (shifted < -lim_o) begin
            shifted = -lim_o;
            r.clamped = 1'b1;
        end
        prev_err_model = err;
        r.drive = shifted[DRIVE_W-1:0];
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_GAIN_P:       kp = data[GAIN_W-1:0];
            REG_GAIN_I:       ki = data[GAIN_W-1:0];
            REG_GAIN_D:       kd = data[GAIN_W-1:0];
            REG_SEP_WINDOW:   sep_window = data[WIN_W-1:0];
            REG_INTEGRAL_MAX: integ_limit = data[IMAX_W-1:0];
            REG_OUT_MAX:      drive_limit = data[OMAX_W-1:0];
            default: ;
        endcase
    endtask

    // Upper data bits beyond a register's width are filled at random; they must be dropped.
    task automatic load_settings(input pid_settings_t s);
        write_reg(REG_GAIN_P, {8'($urandom), s.kp});
        write_reg(REG_GAIN_I, {8'($urandom), s.ki});
        write_reg(REG_GAIN_D, {8'($urandom), s.kd});
        write_reg(REG_SEP_WINDOW, {8'($urandom), s.window});
        write_reg(REG_INTEGRAL_MAX, s.imax);
        write_reg(REG_OUT_MAX, {9'($urandom), s.omax});
        write_reg(REG_SPARE_LO, 24'($urandom));
        write_reg(REG_SPARE_HI, 24'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (drive_queue.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_sample(input logic signed [IN_W-1:0] tgt,
                               input logic signed [IN_W-1:0] meas,
                               input bit typed, input pid_result_t want);
        int          gap;
        pid_result_t predicted;
        gap = draw_gap(send_steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {meas, tgt};
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = predict_drive(tgt, meas);
        drive_queue.push_back(typed ? want : predicted);
    endtask

    // Mostly small or typical values, with the two extremes now and then.
    function automatic logic [31:0] pick_value(input int unsigned hi, input int unsigned typical);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return hi;
            2, 3:    return $urandom_range(0, hi);
            default: return $urandom_range(0, typical);
        endcase
    endfunction

    function automatic pid_settings_t random_settings();
        pid_settings_t s;
        s.kp     = GAIN_W'(pick_value(65535, 1024));
        s.ki     = GAIN_W'(pick_value(65535, 128));
        s.kd     = GAIN_W'(pick_value(65535, 512));
        s.window = WIN_W'(pick_value(65535, 3000));
        s.imax   = IMAX_W'(pick_value(24'hFFFFFF, 100000));
        s.omax   = OMAX_W'(pick_value(32767, 32767));
        return s;
    endfunction

    // Result side: random stalls, then check each accepted result in order.
    initial begin
        int          gap;
        pid_result_t want;
        forever begin
            gap = draw_gap(recv_steady);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1 || aresetn !== 1'b1);
            if (drive_queue.size() == 0) begin
                flag_mismatch($sformatf("result drive=%0d with no request pending",
                                        $signed(m_tdata)));
            end else begin
                want = drive_queue.pop_front();
                if (m_tdata !== want.drive)
                    flag_mismatch($sformatf("drive %0d, expected %0d",
                                            $signed(m_tdata), want.drive));
                if (m_tuser !== want.clamped)
                    flag_mismatch($sformatf("clamped %b, expected %b",
                                            m_tuser, want.clamped));
            end
        end
    end

    initial begin
        int            current;
        int            random_count;
        int            phase_len;
        int            span;
        int            walk;
        int            err;
        logic [31:0]   noise;
        pid_settings_t s;
        kp             = '0;
        ki             = '0;
        kd             = '0;
        sep_window     = '0;
        integ_limit    = '0;
        drive_limit    = OUT_MAX_RESET;
        integ_acc      = 0;
        prev_err_model = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        current = 0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].setting != current) begin
                wait_idle();
                current = directed_rows[i].setting;
                load_settings(directed_settings[current]);
            end
            send_sample(directed_rows[i].target, directed_rows[i].measured,
                        directed_rows[i].typed,
                        '{drive: directed_rows[i].drive, clamped: directed_rows[i].clamped});
        end

        // Random phases: a fresh setting each time, the plant tracking the set point
        // most of the time so the integral builds up, with full-range samples mixed in.
        random_count = 0;
        walk = 0;
        while (random_count < RANDOM_ITEMS) begin
            wait_idle();
            s = random_settings();
            load_settings(s);
            span = (s.window > 2000) ? 2000 : int'(s.window) + 20;
            phase_len = $urandom_range(40, 90);
            for (int n = 0; n < phase_len && random_count < RANDOM_ITEMS; n++) begin
                noise = $urandom();
                if ($urandom_range(0, 3) == 0) begin
                    send_sample(noise[15:0], noise[31:16], 1'b0, '0);
                end else begin
                    walk = sat16(walk + int'($urandom_range(0, 400)) - 200);
                    err  = int'($urandom_range(0, 2 * span)) - span;
                    send_sample(walk[IN_W-1:0], sat16(walk - err), 1'b0, '0);
                end
                random_count++;
            end
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
